// ----- src/pe_pkg.sv -----
// Shared constants, item types and fixed-point helpers for the particle step pipeline.
// No dependencies; every other file refers to it by scoped names.
package pe_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int AXES         = 3;
  localparam int DIV_STEPS    = 32;
  localparam int FORCE_STAGES = 4;
  localparam int UPD_STAGES   = 3;
  localparam int PIPE_LAT     = FORCE_STAGES + DIV_STEPS + UPD_STAGES;

  localparam logic [30:0] TIME_STEP_RST = 31'((1 << FRAC_BITS) / 100);
  localparam logic [30:0] DRAG_RST      = 31'(1 << (FRAC_BITS - 1));
  localparam logic [31:0] S32_MAX       = 32'h7fff_ffff;
  localparam logic [31:0] S32_MIN       = 32'h8000_0000;

  typedef enum logic [2:0] {
    CFG_TIME_STEP = 3'd0,
    CFG_GRAVITY_X = 3'd1,
    CFG_GRAVITY_Y = 3'd2,
    CFG_GRAVITY_Z = 3'd3,
    CFG_DRAG      = 3'd4
  } pe_cfg_t;

  typedef struct packed {
    logic        neg;
    logic        ovf;
    logic [30:0] rem;
    logic [31:0] nq;
  } pe_div_t;

  typedef struct packed {
    logic [AXES-1:0][31:0] new_pos;
    logic [AXES-1:0][31:0] vel;
    logic [30:0]           mass;
    pe_div_t [AXES-1:0]    div;
  } pe_item_t;

  function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    smul = 64'(a) * 64'(b);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = S32_MAX;
    end else if (v < -64'sd2147483648) begin
      sat32 = S32_MIN;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ----- src/pe_force.sv -----
// Front stages: force products, position update, force magnitude and divider setup.
// Depends on pe_pkg.
module pe_force (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [2:0][31:0]      in_pos,
  input  logic [2:0][31:0]      in_vel,
  input  logic [30:0]           in_mass,
  input  logic [30:0]           time_step,
  input  logic [30:0]           drag,
  input  logic [2:0][31:0]      gravity,
  output logic                  out_valid,
  output pe_pkg::pe_item_t      out_item
);

  logic s1_v_r, s2_v_r, s3_v_r, s4_v_r;

  logic [2:0][31:0]   s1_pos_r, s1_vel_r, s2_vel_r, s3_vel_r;
  logic [2:0][31:0]   npos_nxt, s2_npos_r, s3_npos_r;
  logic [30:0]        s1_mass_r, s2_mass_r, s3_mass_r;
  logic signed [63:0] mg_nxt [3];
  logic signed [63:0] dv_nxt [3];
  logic signed [63:0] pv_nxt [3];
  logic signed [63:0] s1_mg_r [3];
  logic signed [63:0] s1_dv_r [3];
  logic signed [63:0] s1_pv_r [3];
  logic signed [63:0] force_nxt [3];
  logic signed [63:0] s2_force_r [3];
  logic [63:0]        mag_nxt [3];
  logic [63:0]        s3_mag_r [3];
  logic [2:0]         neg_nxt, s3_neg_r;
  pe_pkg::pe_item_t   item_nxt, item_r;

  always_comb begin
    for (int a = 0; a < pe_pkg::AXES; a++) begin
      mg_nxt[a] = pe_pkg::smul($signed({1'b0, in_mass}), $signed(gravity[a]));
      dv_nxt[a] = pe_pkg::smul($signed({1'b0, drag}), $signed(in_vel[a]));
      pv_nxt[a] = pe_pkg::smul($signed({1'b0, time_step}), $signed(in_vel[a]));
      force_nxt[a] = s1_mg_r[a] - s1_dv_r[a];
      npos_nxt[a] = pe_pkg::sat32(64'($signed(s1_pos_r[a]))
                                  + (s1_pv_r[a] >>> pe_pkg::FRAC_BITS));
      neg_nxt[a] = s2_force_r[a][63];
      mag_nxt[a] = neg_nxt[a] ? 64'(-s2_force_r[a]) : 64'(s2_force_r[a]);
    end
  end

  always_comb begin
    item_nxt.new_pos = s3_npos_r;
    item_nxt.vel     = s3_vel_r;
    item_nxt.mass    = s3_mass_r;
    for (int a = 0; a < pe_pkg::AXES; a++) begin
      item_nxt.div[a].neg = s3_neg_r[a];
      item_nxt.div[a].ovf = s3_mag_r[a][63:32] >= {1'b0, s3_mass_r};
      item_nxt.div[a].rem = s3_mag_r[a][62:32];
      item_nxt.div[a].nq  = s3_mag_r[a][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_pos_r  <= in_pos;
    s1_vel_r  <= in_vel;
    s1_mass_r <= in_mass;
    s1_mg_r   <= mg_nxt;
    s1_dv_r   <= dv_nxt;
    s1_pv_r   <= pv_nxt;

    s2_vel_r   <= s1_vel_r;
    s2_mass_r  <= s1_mass_r;
    s2_force_r <= force_nxt;
    s2_npos_r  <= npos_nxt;

    s3_vel_r  <= s2_vel_r;
    s3_mass_r <= s2_mass_r;
    s3_npos_r <= s2_npos_r;
    s3_neg_r  <= neg_nxt;
    s3_mag_r  <= mag_nxt;

    item_r <= item_nxt;
  end

  assign out_valid = s4_v_r;
  assign out_item  = item_r;

endmodule

// ----- src/pe_div_step.sv -----
// One restoring-division stage: one quotient bit per axis for force over mass.
// Depends on pe_pkg.
module pe_div_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  pe_pkg::pe_item_t in_item,
  output logic             out_valid,
  output pe_pkg::pe_item_t out_item
);

  logic [31:0]      trial [3];
  logic [31:0]      diff [3];
  logic [2:0]       ge;
  logic             valid_r;
  pe_pkg::pe_item_t item_nxt, item_r;

  always_comb begin
    item_nxt = in_item;
    for (int a = 0; a < pe_pkg::AXES; a++) begin
      trial[a] = {in_item.div[a].rem, in_item.div[a].nq[31]};
      diff[a]  = trial[a] - {1'b0, in_item.mass};
      ge[a]    = trial[a] >= {1'b0, in_item.mass};
      item_nxt.div[a].rem = ge[a] ? diff[a][30:0] : trial[a][30:0];
      item_nxt.div[a].nq  = {in_item.div[a].nq[30:0], ge[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

// ----- src/pe_update.sv -----
// Back stages: saturated acceleration, step product and velocity update.
// Depends on pe_pkg.
module pe_update (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  pe_pkg::pe_item_t in_item,
  input  logic [30:0]      time_step,
  output logic             out_valid,
  output logic [2:0][31:0] new_pos,
  output logic [2:0][31:0] new_vel
);

  logic               u1_v_r, u2_v_r, u3_v_r;
  logic [2:0][31:0]   accel_nxt, u1_accel_r;
  logic [2:0][31:0]   u1_vel_r, u2_vel_r, u1_pos_r, u2_pos_r, u3_pos_r;
  logic signed [63:0] prod_nxt [3];
  logic signed [63:0] u2_prod_r [3];
  logic [2:0][31:0]   nvel_nxt, u3_vel_r;
  logic [31:0]        quo [3];

  always_comb begin
    for (int a = 0; a < pe_pkg::AXES; a++) begin
      quo[a] = in_item.div[a].nq;
      if (in_item.mass == '0) begin
        accel_nxt[a] = '0;
      end else if (in_item.div[a].ovf) begin
        accel_nxt[a] = in_item.div[a].neg ? pe_pkg::S32_MIN : pe_pkg::S32_MAX;
      end else if (!in_item.div[a].neg) begin
        accel_nxt[a] = quo[a][31] ? pe_pkg::S32_MAX : quo[a];
      end else begin
        accel_nxt[a] = (quo[a] > pe_pkg::S32_MIN) ? pe_pkg::S32_MIN : 32'(32'd0 - quo[a]);
      end
      prod_nxt[a] = pe_pkg::smul($signed({1'b0, time_step}), $signed(u1_accel_r[a]));
      nvel_nxt[a] = pe_pkg::sat32(64'($signed(u2_vel_r[a]))
                                  + (u2_prod_r[a] >>> pe_pkg::FRAC_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u1_v_r <= 1'b0;
      u2_v_r <= 1'b0;
      u3_v_r <= 1'b0;
    end else begin
      u1_v_r <= in_valid;
      u2_v_r <= u1_v_r;
      u3_v_r <= u2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    u1_accel_r <= accel_nxt;
    u1_vel_r   <= in_item.vel;
    u1_pos_r   <= in_item.new_pos;
    u2_prod_r  <= prod_nxt;
    u2_vel_r   <= u1_vel_r;
    u2_pos_r   <= u1_pos_r;
    u3_vel_r   <= nvel_nxt;
    u3_pos_r   <= u2_pos_r;
  end

  assign out_valid = u3_v_r;
  assign new_pos   = u3_pos_r;
  assign new_vel   = u3_vel_r;

endmodule

// ----- src/particle_euler_gravity_drag_step.sv -----
// Top level: configuration registers and the full Euler step pipeline.
// Depends on pe_pkg, pe_force, pe_div_step and pe_update.
//
//   channel   handshake              payload
//   input     start / busy           in_pos_*, in_vel_*, in_mass
//   result    out_valid (strobe)     out_new_pos_*, out_new_vel_*
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item enters per cycle; busy stays low and cfg_ready stays high.
// Each result passes through 4 force stages, 32 divider
// stages (one quotient bit each) and 3 update stages.
// Synchronous reset clears the valid bits and loads the register defaults.
// Results appear as one-cycle strobes; the pipeline never stalls.
module particle_euler_gravity_drag_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_vel_x,
  input  logic signed [31:0] in_vel_y,
  input  logic signed [31:0] in_vel_z,
  input  logic [30:0]        in_mass,
  output logic               out_valid,
  output logic signed [31:0] out_new_pos_x,
  output logic signed [31:0] out_new_pos_y,
  output logic signed [31:0] out_new_pos_z,
  output logic signed [31:0] out_new_vel_x,
  output logic signed [31:0] out_new_vel_y,
  output logic signed [31:0] out_new_vel_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [30:0]      time_step_r, drag_r;
  logic [2:0][31:0] gravity_r;
  logic [2:0][31:0] pos_in, vel_in, npos, nvel;

  logic             chain_v [pe_pkg::DIV_STEPS+1];
  pe_pkg::pe_item_t chain_item [pe_pkg::DIV_STEPS+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= pe_pkg::TIME_STEP_RST;
      gravity_r   <= '0;
      drag_r      <= pe_pkg::DRAG_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pe_pkg::CFG_TIME_STEP: time_step_r  <= cfg_data[30:0];
        pe_pkg::CFG_GRAVITY_X: gravity_r[0] <= cfg_data;
        pe_pkg::CFG_GRAVITY_Y: gravity_r[1] <= cfg_data;
        pe_pkg::CFG_GRAVITY_Z: gravity_r[2] <= cfg_data;
        pe_pkg::CFG_DRAG:      drag_r       <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign pos_in = {in_pos_z, in_pos_y, in_pos_x};
  assign vel_in = {in_vel_z, in_vel_y, in_vel_x};

  pe_force u_force (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_pos    (pos_in),
    .in_vel    (vel_in),
    .in_mass   (in_mass),
    .time_step (time_step_r),
    .drag      (drag_r),
    .gravity   (gravity_r),
    .out_valid (chain_v[0]),
    .out_item  (chain_item[0])
  );

  for (genvar k = 0; k < pe_pkg::DIV_STEPS; k++) begin : g_div
    pe_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_v[k]),
      .in_item   (chain_item[k]),
      .out_valid (chain_v[k+1]),
      .out_item  (chain_item[k+1])
    );
  end

  pe_update u_update (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chain_v[pe_pkg::DIV_STEPS]),
    .in_item   (chain_item[pe_pkg::DIV_STEPS]),
    .time_step (time_step_r),
    .out_valid (out_valid),
    .new_pos   (npos),
    .new_vel   (nvel)
  );

  assign out_new_pos_x = npos[0];
  assign out_new_pos_y = npos[1];
  assign out_new_pos_z = npos[2];
  assign out_new_vel_x = nvel[0];
  assign out_new_vel_y = nvel[1];
  assign out_new_vel_z = nvel[2];

endmodule

// ----- src/pe_checker.sv -----
// Port-level checks on latency, reset and the zero-mass case, bound to the top level.
// Depends on pe_pkg and particle_euler_gravity_drag_step.
module pe_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [30:0]        in_mass,
  input logic signed [31:0] in_vel_x,
  input logic               out_valid,
  input logic signed [31:0] out_new_vel_x
);

  localparam int CNT_W = $clog2(pe_pkg::PIPE_LAT + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(pe_pkg::PIPE_LAT);

  logic [CNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cnt_r != CNT_FULL) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_FULL) |-> (out_valid == $past(start && !busy, pe_pkg::PIPE_LAT)))
    else $error("result strobe does not match an accepted item");

  a_zero_mass: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == CNT_FULL && out_valid && $past(in_mass == '0, pe_pkg::PIPE_LAT))
      |-> (out_new_vel_x == $past(in_vel_x, pe_pkg::PIPE_LAT)))
    else $error("zero-mass item changed its velocity");

endmodule

bind particle_euler_gravity_drag_step pe_checker u_chk (.*);

// ----- dv/tb_particle_euler_gravity_drag_step.sv -----
// Self-checking testbench for particle_euler_gravity_drag_step: table-driven directed
// particles, then randomized register settings and particles, checked against stored
// results or a local Euler step predictor. Depends on pe_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_particle_euler_gravity_drag_step;

  localparam int          WATCHDOG_CYCLES = 1000;
  localparam int          PHASES          = 10;
  localparam int          ITEMS_PER_PHASE = 95;
  localparam int          N_DIRECTED      = 14;
  localparam logic [2:0]  CFG_UNMAPPED_LO = 3'd5;
  localparam logic [2:0]  CFG_UNMAPPED_HI = 3'd7;
  localparam logic [31:0] POS_MAX         = pe_pkg::S32_MAX;
  localparam logic [31:0] POS_MIN         = pe_pkg::S32_MIN;

  // order: pos x, y, z, vel x, y, z
  typedef logic [0:5][31:0] kin_t;

  typedef struct packed {
    kin_t        pv;
    logic [30:0] mass;
  } particle_t;

  typedef struct packed {
    logic      typed;
    particle_t p;
    kin_t      want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic signed [31:0] in_vel_x, in_vel_y, in_vel_z;
  logic [30:0] in_mass;
  logic        out_valid;
  logic signed [31:0] out_new_pos_x, out_new_pos_y, out_new_pos_z;
  logic signed [31:0] out_new_vel_x, out_new_vel_y, out_new_vel_z;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  logic [30:0]        step_q;
  logic signed [31:0] gravity_q [3];
  logic [30:0]        viscosity_q;

  kin_t  expected_kin [$];
  int    fail_count;
  int    idle_cycles;
  string field_name [6] = '{"new_pos_x", "new_pos_y", "new_pos_z",
                            "new_vel_x", "new_vel_y", "new_vel_z"};

  stim_row_t directed_tab [N_DIRECTED] = '{
    '{1'b1, '{'{0, 0, 0, 0, 0, 0}, 31'd65536}, '{0, 0, 0, 0, 0, 0}},
    '{1'b1, '{'{1234, -5, POS_MAX, 6553600, -6553600, 0}, 31'd0},
            '{66734, -65505, POS_MAX, 6553600, -6553600, 0}},
    '{1'b1, '{'{0, 0, 0, -1, 1, 0}, 31'd65536}, '{-1, 0, 0, -1, 1, 0}},
    '{1'b1, '{'{100, -100, 0, 0, 0, 0}, 31'h7fff_ffff}, '{100, -100, 0, 0, 0, 0}},
    '{1'b0, '{'{POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX}, 31'h7fff_ffff},
            '{0, 0, 0, 0, 0, 0}},
    '{1'b0, '{'{POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN}, 31'd1},
            '{0, 0, 0, 0, 0, 0}},
    '{1'b0, '{'{POS_MAX, POS_MIN, 0, POS_MAX, POS_MIN, 1}, 31'd1}, '{0, 0, 0, 0, 0, 0}},
    '{1'b0, '{'{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa}, 31'h2aaa_aaaa},
            '{0, 0, 0, 0, 0, 0}},
    '{1'b0, '{'{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555}, 31'h5555_5555},
            '{0, 0, 0, 0, 0, 0}},
    '{1'b0, '{'{0, 0, 0, 5, -5, 7}, 31'd3}, '{0, 0, 0, 0, 0, 0}},
    '{1'b0, '{'{10 << 16, -(3 << 16), 1 << 16, 2 << 16, -(1 << 15), 0}, 31'd131072},
            '{0, 0, 0, 0, 0, 0}},
    '{1'b0, '{'{-1, -1, -1, -1, -1, -1}, 31'd1}, '{0, 0, 0, 0, 0, 0}},
    '{1'b0, '{'{POS_MIN, POS_MAX, 0, POS_MIN, POS_MAX, -1}, 31'd0}, '{0, 0, 0, 0, 0, 0}},
    '{1'b0, '{'{0, 0, 0, 65536, -65536, 32768}, 31'd1}, '{0, 0, 0, 0, 0, 0}}
  };

  particle_euler_gravity_drag_step uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .in_vel_x      (in_vel_x),
    .in_vel_y      (in_vel_y),
    .in_vel_z      (in_vel_z),
    .in_mass       (in_mass),
    .out_valid     (out_valid),
    .out_new_pos_x (out_new_pos_x),
    .out_new_pos_y (out_new_pos_y),
    .out_new_pos_z (out_new_pos_z),
    .out_new_vel_x (out_new_vel_x),
    .out_new_vel_y (out_new_vel_y),
    .out_new_vel_z (out_new_vel_z),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] clip_s32(input longint v);
    if (v > longint'(2147483647)) begin
      clip_s32 = POS_MAX;
    end else if (v < -64'sd2147483648) begin
      clip_s32 = POS_MIN;
    end else begin
      clip_s32 = v[31:0];
    end
  endfunction

  function automatic kin_t euler_step(input particle_t p);
    kin_t   r;
    longint m;
    longint vel;
    longint net_f;
    longint accel;
    int     ax;
    m = longint'(p.mass);
    for (ax = 0; ax < 3; ax++) begin
      vel   = longint'($signed(p.pv[3 + ax]));
      net_f = m * longint'(gravity_q[ax]) - longint'(viscosity_q) * vel;
      if (m == 0) begin
        accel = 0;
      end else begin
        accel = clip_s32(net_f / m);
      end
      r[ax]     = clip_s32(longint'($signed(p.pv[ax])) +
                           ((longint'(step_q) * vel) >>> pe_pkg::FRAC_BITS));
      r[3 + ax] = clip_s32(vel + ((longint'(step_q) * accel) >>> pe_pkg::FRAC_BITS));
    end
    return r;
  endfunction

  function automatic logic [31:0] draw_coord();
    case ($urandom_range(0, 3))
      0: draw_coord = $urandom_range(0, 1 << 23) - (1 << 22);
      1: draw_coord = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
      default: draw_coord = $urandom;
    endcase
  endfunction

  function automatic logic [30:0] draw_mass();
    case ($urandom_range(0, 4))
      0: draw_mass = $urandom_range(1, 16);
      1: draw_mass = 31'h7fff_ffff;
      2: draw_mass = $urandom_range(1, 31'h7fff_ffff);
      default: draw_mass = $urandom_range(1 << 12, 1 << 20);
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    repeat ($urandom_range(0, 3)) begin
      @(negedge clk);
      cfg_valid <= 1'b0;
    end
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pe_pkg::CFG_TIME_STEP: step_q       = data[30:0];
      pe_pkg::CFG_GRAVITY_X: gravity_q[0] = data;
      pe_pkg::CFG_GRAVITY_Y: gravity_q[1] = data;
      pe_pkg::CFG_GRAVITY_Z: gravity_q[2] = data;
      pe_pkg::CFG_DRAG:      viscosity_q  = data[30:0];
      default: ;
    endcase
  endtask

  task automatic drive_particle(input particle_t p, input int gap, input kin_t want);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start    <= 1'b1;
    in_pos_x <= p.pv[0];
    in_pos_y <= p.pv[1];
    in_pos_z <= p.pv[2];
    in_vel_x <= p.pv[3];
    in_vel_y <= p.pv[4];
    in_vel_z <= p.pv[5];
    in_mass  <= p.mass;
    do @(posedge clk); while (busy);
    expected_kin = {expected_kin, want};
  endtask

  task automatic wait_drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_kin.size() != 0) @(posedge clk);
  endtask

  // sel: 0 low extreme, 1 high extreme, 2 small, 3 or more random; negative draws one per register
  task automatic program_phase(input int sel);
    int          k;
    int          pick;
    logic [31:0] d;
    pick = sel;
    if (pick < 0) pick = $urandom_range(0, 4);
    case (pick)
      0: d = 32'h0;
      1: d = 32'h7fff_ffff;
      2: d = $urandom_range(0, 1 << 17);
      default: d = $urandom;
    endcase
    d[31] = $urandom_range(0, 1);
    write_reg(pe_pkg::CFG_TIME_STEP, d);
    for (k = 0; k < 3; k++) begin
      pick = sel;
      if (pick < 0) pick = $urandom_range(0, 4);
      case (pick)
        0: d = POS_MIN;
        1: d = POS_MAX;
        2: d = $urandom_range(0, 40 << 16) - (20 << 16);
        default: d = $urandom;
      endcase
      write_reg(3'(pe_pkg::CFG_GRAVITY_X + k), d);
    end
    pick = sel;
    if (pick < 0) pick = $urandom_range(0, 4);
    case (pick)
      0: d = 32'h0;
      1: d = 32'h7fff_ffff;
      2: d = $urandom_range(0, 4 << 16);
      default: d = $urandom;
    endcase
    d[31] = $urandom_range(0, 1);
    write_reg(pe_pkg::CFG_DRAG, d);
    write_reg(3'($urandom_range(CFG_UNMAPPED_LO, CFG_UNMAPPED_HI)), $urandom);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    kin_t got;
    kin_t want;
    int   i;
    got = {out_new_pos_x, out_new_pos_y, out_new_pos_z,
           out_new_vel_x, out_new_vel_y, out_new_vel_z};
    if (rst_n && out_valid === 1'b1) begin
      if (expected_kin.size() == 0) begin
        $error("result with no item pending");
        fail_count++;
      end else begin
        want = expected_kin.pop_front();
        for (i = 0; i < 6; i++) begin
          if (got[i] !== want[i]) begin
            $error("%s: expected %0d, got %0d", field_name[i], $signed(want[i]),
                   $signed(got[i]));
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    particle_t p;
    int        r;
    int        ph;
    int        n;
    int        k;
    int        burst_left;
    int        gap;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_pos_x    = '0;
    in_pos_y    = '0;
    in_pos_z    = '0;
    in_vel_x    = '0;
    in_vel_y    = '0;
    in_vel_z    = '0;
    in_mass     = '0;
    cfg_valid   = 1'b0;
    cfg_index   = pe_pkg::CFG_TIME_STEP;
    cfg_data    = '0;
    fail_count  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    step_q       = pe_pkg::TIME_STEP_RST;
    gravity_q[0] = '0;
    gravity_q[1] = '0;
    gravity_q[2] = '0;
    viscosity_q  = pe_pkg::DRAG_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < N_DIRECTED; r++) begin
      drive_particle(directed_tab[r].p, $urandom_range(0, 11),
                     directed_tab[r].typed ? directed_tab[r].want
                                           : euler_step(directed_tab[r].p));
    end

    for (ph = 1; ph <= PHASES; ph++) begin
      wait_drain();
      program_phase(ph == 1 ? 0 : ph == 2 ? 1 : -1);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        for (k = 0; k < 6; k++) p.pv[k] = draw_coord();
        p.mass = draw_mass();
        // alternate bursts with no gaps and stretches of random gaps
        if (burst_left > 0) begin
          burst_left--;
          gap = 0;
        end else begin
          gap = $urandom_range(0, 11);
          if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(5, 30);
        end
        drive_particle(p, gap, euler_step(p));
      end
    end
    @(negedge clk);
    start <= 1'b0;

    wait_drain();
    repeat (pe_pkg::PIPE_LAT + 10) @(posedge clk);
    if (fail_count == 0 && expected_kin.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/pe_pkg.sv
src/pe_force.sv
src/pe_div_step.sv
src/pe_update.sv
src/particle_euler_gravity_drag_step.sv
src/pe_checker.sv
dv/tb_particle_euler_gravity_drag_step.sv
